/* rtl/vnf_pkg.sv */
// Shared constants, types and tables for the fractal value noise core.
`timescale 1ns / 1ps
`default_nettype none
package vnf_pkg;
   localparam int MAX_OCTAVES = 8;
   localparam int FRAC_BITS = 16;
   localparam int OCT_W = 4;
   localparam int V16_W = 16;
   localparam int ACC_W = 24;
   localparam int CNT_W = 4;
   localparam logic [OCT_W-1:0] OCT_RESET = 4'd3;
   localparam logic [31:0] HASH_MUL_X = 32'd374761393;
   localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
   localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [CNT_W-1:0] count;
   } ctl_type;

   typedef logic [V16_W-1:0] v16_arr_type [MAX_OCTAVES];

   // ceil(2^32 / (2^k - 1)); one octave bypasses the multiply
   function automatic logic [31:0] recip(input logic [CNT_W-1:0] k);
      logic [31:0] r;
      case (k)
         4'd2: r = 32'd1431655766;
         4'd3: r = 32'd613566757;
         4'd4: r = 32'd286331154;
         4'd5: r = 32'd138547333;
         4'd6: r = 32'd68174085;
         4'd7: r = 32'd33818641;
         4'd8: r = 32'd16843010;
         default: r = 32'd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

/* rtl/value_noise_fbm_2d_core.sv */
// Top level of the pipelined 2-D fractal value noise core.
`timescale 1ns / 1ps
`default_nettype none
// One point enters per cycle (busy stays low); its noise word is strobed on rsp_noise_value
// with rsp_valid after an input register, parallel five-stage octave lanes, a two-stage
// summing tree and the normalizing multiply stage. The receiver cannot stall, so results
// are never held. csr_octave_count may only be written while no point is in flight.
module value_noise_fbm_2d_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_start,
   output logic             busy,
   input  wire logic [31:0] req_coord_x,
   input  wire logic [31:0] req_coord_y,
   output logic             rsp_valid,
   output logic [15:0]      rsp_noise_value,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_octave_count
);
   localparam int N = vnf_pkg::MAX_OCTAVES;
   localparam int LANE_DEPTH = 5;

   logic [3:0] oct_ff;
   logic [31:0] x_ff, y_ff;
   vnf_pkg::ctl_type c0_ff, c0_in;
   vnf_pkg::ctl_type cp_ff [LANE_DEPTH];
   vnf_pkg::v16_arr_type v16;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      c0_in.valid = req_start;
      c0_in.zero = (oct_ff == 4'd0);
      c0_in.count = (oct_ff > 4'(N)) ? 4'(N) : oct_ff;
   end

   always_ff @(posedge clock) begin
      x_ff <= req_coord_x;
      y_ff <= req_coord_y;
      if (reset) begin
         oct_ff <= vnf_pkg::OCT_RESET;
         c0_ff <= '0;
         for (int i = 0; i < LANE_DEPTH; i++) begin
            cp_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            oct_ff <= csr_octave_count;
         end
         c0_ff <= c0_in;
         cp_ff[0] <= c0_ff;
         for (int i = 1; i < LANE_DEPTH; i++) begin
            cp_ff[i] <= cp_ff[i-1];
         end
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_lane
      vnf_octave u_oct (
         .clock (clock),
         .x     (x_ff << g),
         .y     (y_ff << g),
         .v16   (v16[g])
      );
   end

   vnf_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cp_ff[LANE_DEPTH-1]),
      .v16       (v16),
      .out_valid (rsp_valid),
      .out_value (rsp_noise_value)
   );
endmodule
`default_nettype wire

/* rtl/vnf_octave.sv */
// One octave lane: lattice hash, smoothstep weights and bilinear blend in five stages.
`timescale 1ns / 1ps
`default_nettype none
module vnf_octave (
   input  wire logic        clock,
   input  wire logic [31:0] x,
   input  wire logic [31:0] y,
   output logic [15:0]      v16
);
   localparam int FB = vnf_pkg::FRAC_BITS;
   localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

   logic [31:0] ix, iy;
   logic [31:0] px0_ff, px1_ff, py0_ff, py1_ff;
   logic [FB-1:0] tx_ff, ty_ff, ttx_ff, tty_ff;
   logic [31:0] h_ff [4];
   logic [31:0] h_in [4];
   logic [FB:0] sx_b_ff, sy_b_ff, sx_c_ff, sy_c_ff, sy_d_ff;
   logic [23:0] c_ff [4];
   logic [23:0] lo_ff, hi_ff;
   logic [15:0] v16_ff;
   logic [2*FB+1:0] sxp, syp;
   logic [2*FB-1:0] ttxp, ttyp;
   logic [24+FB:0] lo_s, hi_s, v_s;
   logic [31:0] hs [4];
   logic [31:0] hm [4];

   assign ix = 32'($signed(x) >>> FB);
   assign iy = 32'($signed(y) >>> FB);
   assign ttxp = x[FB-1:0] * x[FB-1:0];
   assign ttyp = y[FB-1:0] * y[FB-1:0];

   always_ff @(posedge clock) begin
      px0_ff <= ix * vnf_pkg::HASH_MUL_X;
      px1_ff <= (ix + 32'd1) * vnf_pkg::HASH_MUL_X;
      py0_ff <= iy * vnf_pkg::HASH_MUL_Y;
      py1_ff <= (iy + 32'd1) * vnf_pkg::HASH_MUL_Y;
      tx_ff <= x[FB-1:0];
      ty_ff <= y[FB-1:0];
      ttx_ff <= ttxp[2*FB-1:FB];
      tty_ff <= ttyp[2*FB-1:FB];
   end

   assign sxp = {2'b0, ttx_ff} * ((FB+2)'(3) * {1'b0, ONE} - {1'b0, tx_ff, 1'b0});
   assign syp = {2'b0, tty_ff} * ((FB+2)'(3) * {1'b0, ONE} - {1'b0, ty_ff, 1'b0});

   always_comb begin
      hs[0] = px0_ff + py0_ff;
      hs[1] = px1_ff + py0_ff;
      hs[2] = px0_ff + py1_ff;
      hs[3] = px1_ff + py1_ff;
      for (int i = 0; i < 4; i++) begin
         h_in[i] = hs[i] ^ (hs[i] >> 13);
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      sx_b_ff <= sxp[2*FB:FB];
      sy_b_ff <= syp[2*FB:FB];
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         hm[i] = h_ff[i] * vnf_pkg::HASH_MUL_MIX;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         c_ff[i] <= hm[i][23:0];
      end
      sx_c_ff <= sx_b_ff;
      sy_c_ff <= sy_b_ff;
   end

   assign lo_s = (25+FB)'(c_ff[0]) * (25+FB)'(ONE - sx_c_ff)
               + (25+FB)'(c_ff[1]) * (25+FB)'(sx_c_ff);
   assign hi_s = (25+FB)'(c_ff[2]) * (25+FB)'(ONE - sx_c_ff)
               + (25+FB)'(c_ff[3]) * (25+FB)'(sx_c_ff);

   always_ff @(posedge clock) begin
      lo_ff <= lo_s[FB+23:FB];
      hi_ff <= hi_s[FB+23:FB];
      sy_d_ff <= sy_c_ff;
   end

   assign v_s = (25+FB)'(lo_ff) * (25+FB)'(ONE - sy_d_ff)
              + (25+FB)'(hi_ff) * (25+FB)'(sy_d_ff);

   always_ff @(posedge clock) begin
      v16_ff <= v_s[FB+23:FB+8];
   end

   assign v16 = v16_ff;
endmodule
`default_nettype wire

/* rtl/vnf_norm.sv */
// Octave weighting, summing tree, reciprocal normalization and saturation.
`timescale 1ns / 1ps
`default_nettype none
module vnf_norm (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire vnf_pkg::ctl_type      ctl,
   input  wire vnf_pkg::v16_arr_type  v16,
   output logic                       out_valid,
   output logic [15:0]                out_value
);
   localparam int N = vnf_pkg::MAX_OCTAVES;
   localparam int AW = vnf_pkg::ACC_W;

   logic [AW-1:0] term [N];
   logic [AW-1:0] part_ff [2];
   logic [AW-1:0] part_in [2];
   logic [AW-1:0] acc_ff;
   vnf_pkg::ctl_type c1_ff, c2_ff;
   logic [AW+31:0] prod;
   logic [AW-1:0] res;
   logic [15:0] value_ff, value_in;
   logic valid_ff;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (vnf_pkg::CNT_W'(i) < ctl.count) begin
            term[i] = AW'(v16[i]) << (ctl.count - vnf_pkg::CNT_W'(i) - 4'd1);
         end else begin
            term[i] = '0;
         end
      end
      part_in[0] = '0;
      part_in[1] = '0;
      for (int i = 0; i < N; i++) begin
         if (i < N / 2) begin
            part_in[0] = part_in[0] + term[i];
         end else begin
            part_in[1] = part_in[1] + term[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      acc_ff <= part_ff[0] + part_ff[1];
   end

   assign prod = acc_ff * vnf_pkg::recip(c2_ff.count);

   always_comb begin
      res = (c2_ff.count == 4'd1) ? acc_ff : prod[AW+31:32];
      if (c2_ff.zero) begin
         value_in = '0;
      end else if (res > AW'(16'hFFFF)) begin
         value_in = 16'hFFFF;
      end else begin
         value_in = res[15:0];
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         c1_ff <= ctl;
         c2_ff <= c1_ff;
         valid_ff <= c2_ff.valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
endmodule
`default_nettype wire

/* rtl/vnf_checker.sv */
// Port-level checker for the fractal value noise core, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module vnf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [15:0] rsp_noise_value,
   input wire logic        csr_valid,
   input wire logic        csr_ready
);
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_start && !busy |-> ##9 rsp_valid) else $error("word lost");
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_start, 9)) else $error("word invented");
   a_zero_oct: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && rsp_noise_value == 16'd0 |-> !busy)
      else $error("busy while configuring");
   a_idle: assert property (@(posedge clock) !busy) else $error("busy raised");
endmodule

bind value_noise_fbm_2d_core vnf_checker u_vnf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_start       (req_start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_noise_value (rsp_noise_value),
   .csr_valid       (csr_valid),
   .csr_ready       (csr_ready)
);
`default_nettype wire
